[hdl/epsc_pkg.sv]
// Shared types and constants of the epoch-seconds to calendar-date unit.
// Holds the reciprocal constants used for the fixed divisions.
// No dependencies.
package epsc_pkg;

    // stage count of the pipeline; stage NUM_STG-1 is the output register
    localparam int NUM_STG = 10;
    typedef logic [NUM_STG-1:0] t_stage_en;

    typedef logic signed [38:0] t_epoch;
    typedef logic signed [14:0] t_year;
    typedef logic [3:0]         t_month;
    typedef logic [4:0]         t_mday;
    typedef logic [4:0]         t_hour;
    typedef logic [5:0]         t_minute;
    typedef logic [5:0]         t_second;

    localparam int DAY_W = 23;   // day number since JD 0
    localparam int SOD_W = 17;   // second of day
    typedef logic [DAY_W-1:0] t_day;
    typedef logic [SOD_W-1:0] t_sod;

    localparam t_epoch      EPOCH_LOW  = -39'sd211813488000;
    localparam t_epoch      EPOCH_HIGH = 39'sd252455572799;
    localparam logic [38:0] JD0_OFFSET = 39'd211813531200;

    // t / 86400 = (t >> 7) / 675, reciprocal with round-up constant
    localparam int          DAY_LSB    = 7;
    localparam int          T1_W       = 32;
    localparam int          DIV675_SH  = 42;
    localparam logic [9:0]  DIV675     = 10'd675;
    localparam logic [32:0] DIV675_M   =
        33'(((64'd1 << DIV675_SH) + 64'd674) / 64'd675);

    // Gregorian correction: a = (4*J - 7468865) / 146097
    localparam t_day        GREG_START = 23'd2299160;
    localparam logic [24:0] A_OFS      = 25'd7468865;
    localparam int          A_SH       = 42;
    localparam logic [24:0] A_M        =
        25'(((64'd1 << A_SH) + 64'd146096) / 64'd146097);
    localparam t_day        JUL_OFS    = 23'd1524;

    // d = (100*c - 12210) / 36525
    localparam logic [29:0] D_SUB      = 30'd12210;
    localparam int          D_SH       = 46;
    localparam logic [30:0] D_M        =
        31'(((64'd1 << D_SH) + 64'd36524) / 64'd36525);
    localparam int          D_W        = 14;

    // e = 36525*d/100 = 1461*d/4
    localparam logic [24:0] E_MUL      = 25'd1461;
    localparam int          CE_W       = 9;

    // g = (ce*10000) / 306001, the *10000 folded into the constant
    localparam int          G_SH       = 42;
    localparam logic [37:0] G_K        =
        38'(64'd10000 * (((64'd1 << G_SH) + 64'd306000) / 64'd306001));

    // floor(30.6001 * g)
    localparam logic [CE_W-1:0] G_DAYS [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    localparam t_year YEAR_OFS_MAR = 15'sd4716;
    localparam t_year YEAR_OFS_JAN = 15'sd4715;

    // time of day: x / 60 by reciprocal
    localparam int          MIN_SH = 23;
    localparam logic [17:0] MIN_M  = 18'(((64'd1 << MIN_SH) + 64'd59) / 64'd60);
    localparam int          HR_SH  = 17;
    localparam logic [11:0] HR_M   = 12'(((64'd1 << HR_SH) + 64'd59) / 64'd60);

endpackage

[hdl/epsc_in_if.sv]
// Input channel of the epoch-seconds to calendar-date unit.
// Depends on epsc_pkg.
interface epsc_in_if;
    import epsc_pkg::*;

    logic   valid;
    logic   ready;
    t_epoch epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

[hdl/epsc_out_if.sv]
// Output channel of the epoch-seconds to calendar-date unit.
// Depends on epsc_pkg.
interface epsc_out_if;
    import epsc_pkg::*;

    logic    valid;
    logic    ready;
    t_year   cal_year;
    t_month  cal_month;
    t_mday   cal_day;
    t_hour   clock_hour;
    t_minute clock_minute;
    t_second clock_second;
    logic    out_of_range;

    modport source (output valid, output cal_year, output cal_month, output cal_day,
                    output clock_hour, output clock_minute, output clock_second,
                    output out_of_range, input ready);
    modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                    input clock_hour, input clock_minute, input clock_second,
                    input out_of_range, output ready);
endinterface

[hdl/epsc_day_split.sv]
// Stages 0 to 2: range check and split of seconds into day number and second of day.
// Depends on epsc_pkg.
module epsc_day_split (
    input  logic               i_clk,
    input  epsc_pkg::t_stage_en i_en,
    input  epsc_pkg::t_epoch   i_epoch,
    output epsc_pkg::t_day     o_day,
    output epsc_pkg::t_sod     o_sod,
    output logic               o_oor
);
    import epsc_pkg::*;

    logic [38:0]     r_t0;
    logic            r_oor0;
    logic [64:0]     r_prod1;
    logic [T1_W-1:0] r_t1;
    logic [DAY_LSB-1:0] r_tlo1;
    logic            r_oor1;
    t_day            r_day2;
    t_sod            r_sod2;
    logic            r_oor2;

    logic [38:0]     n_t;
    logic            n_oor;
    t_day            n_q;
    logic [T1_W-1:0] n_rem;

    // shift to a midnight-based count from JD 0; wraps harmlessly when out of range
    assign n_t   = 39'($unsigned(i_epoch)) + JD0_OFFSET;
    assign n_oor = (i_epoch < EPOCH_LOW) || (i_epoch > EPOCH_HIGH);

    assign n_q   = r_prod1[DIV675_SH +: DAY_W];
    assign n_rem = r_t1 - T1_W'(T1_W'(n_q) * T1_W'(DIV675));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t0   <= n_t;
            r_oor0 <= n_oor;
        end
        if (i_en[1]) begin
            r_prod1 <= 65'(r_t0[38:DAY_LSB]) * 65'(DIV675_M);
            r_t1    <= r_t0[38:DAY_LSB];
            r_tlo1  <= r_t0[DAY_LSB-1:0];
            r_oor1  <= r_oor0;
        end
        if (i_en[2]) begin
            r_day2 <= n_q;
            r_sod2 <= {n_rem[9:0], r_tlo1};
            r_oor2 <= r_oor1;
        end
    end

    assign o_day = r_day2;
    assign o_sod = r_sod2;
    assign o_oor = r_oor2;
endmodule

[hdl/epsc_time_of_day.sv]
// Stages 3 to 8: second of day into hour, minute and second.
// Depends on epsc_pkg.
module epsc_time_of_day (
    input  logic                i_clk,
    input  epsc_pkg::t_stage_en i_en,
    input  epsc_pkg::t_sod      i_sod,
    output epsc_pkg::t_hour     o_hour,
    output epsc_pkg::t_minute   o_minute,
    output epsc_pkg::t_second   o_second
);
    import epsc_pkg::*;

    logic [34:0] r_prod_m3;
    t_sod        r_sod3;
    logic [10:0] r_min4;
    t_second     r_sec4;
    logic [22:0] r_prod_h5;
    logic [10:0] r_min5;
    t_second     r_sec5;
    t_hour       r_hour6, r_hour7, r_hour8;
    t_minute     r_minute6, r_minute7, r_minute8;
    t_second     r_sec6, r_sec7, r_sec8;

    logic [10:0] n_m;
    t_sod        n_s;
    t_hour       n_h;
    logic [10:0] n_mi;

    assign n_m  = r_prod_m3[MIN_SH +: 11];
    assign n_s  = r_sod3 - SOD_W'(SOD_W'(n_m) * SOD_W'(60));
    assign n_h  = r_prod_h5[HR_SH +: 5];
    assign n_mi = r_min5 - 11'(11'(n_h) * 11'd60);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_prod_m3 <= 35'(i_sod) * 35'(MIN_M);
            r_sod3    <= i_sod;
        end
        if (i_en[4]) begin
            r_min4 <= n_m;
            r_sec4 <= n_s[5:0];
        end
        if (i_en[5]) begin
            r_prod_h5 <= 23'(r_min4) * 23'(HR_M);
            r_min5    <= r_min4;
            r_sec5    <= r_sec4;
        end
        if (i_en[6]) begin
            r_hour6   <= n_h;
            r_minute6 <= n_mi[5:0];
            r_sec6    <= r_sec5;
        end
        // align with the date path
        if (i_en[7]) begin
            r_hour7   <= r_hour6;
            r_minute7 <= r_minute6;
            r_sec7    <= r_sec6;
        end
        if (i_en[8]) begin
            r_hour8   <= r_hour7;
            r_minute8 <= r_minute7;
            r_sec8    <= r_sec7;
        end
    end

    assign o_hour   = r_hour8;
    assign o_minute = r_minute8;
    assign o_second = r_sec8;
endmodule

[hdl/epsc_date.sv]
// Stages 3 to 8: day number into year, month and day (Julian-day inverse).
// Depends on epsc_pkg.
module epsc_date (
    input  logic                i_clk,
    input  epsc_pkg::t_stage_en i_en,
    input  epsc_pkg::t_day      i_day,
    output epsc_pkg::t_year     o_year,
    output epsc_pkg::t_month    o_month,
    output epsc_pkg::t_mday     o_mday
);
    import epsc_pkg::*;

    logic [48:0]     r_prod_a3;
    t_day            r_day3;
    logic            r_greg3;
    t_day            r_c4, r_c5, r_c6;
    logic [29:0]     r_num_d5;
    logic [60:0]     r_prod_d6;
    logic [D_W-1:0]  r_d7, r_d8;
    logic [CE_W-1:0] r_ce7, r_ce8;
    logic [46:0]     r_prod_g8;

    logic [24:0]     n_a_num;
    logic [6:0]      n_a;
    t_day            n_c;
    logic [D_W-1:0]  n_d;
    logic [24:0]     n_e4;
    t_day            n_ce;
    logic [3:0]      n_g;
    t_month          n_month;

    // only meaningful past the calendar switch, where it is positive
    assign n_a_num = {i_day, 2'b00} - A_OFS;

    assign n_a = r_prod_a3[A_SH +: 7];
    assign n_c = r_greg3 ? r_day3 + DAY_W'(n_a) - DAY_W'(n_a >> 2) + DAY_W'(1) + JUL_OFS
                         : r_day3 + JUL_OFS;

    assign n_d  = r_prod_d6[D_SH +: D_W];
    assign n_e4 = 25'(n_d) * E_MUL;
    assign n_ce = r_c6 - n_e4[24:2];

    assign n_g     = r_prod_g8[G_SH +: 4];
    assign n_month = (n_g <= 4'd13) ? n_g - 4'd1 : n_g - 4'd13;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_prod_a3 <= 49'(n_a_num[23:0]) * 49'(A_M);
            r_day3    <= i_day;
            r_greg3   <= i_day > GREG_START;
        end
        if (i_en[4]) begin
            r_c4 <= n_c;
        end
        if (i_en[5]) begin
            r_num_d5 <= 30'(r_c4) * 30'd100 - D_SUB;
            r_c5     <= r_c4;
        end
        if (i_en[6]) begin
            r_prod_d6 <= 61'(r_num_d5) * 61'(D_M);
            r_c6      <= r_c5;
        end
        if (i_en[7]) begin
            r_d7  <= n_d;
            r_ce7 <= n_ce[CE_W-1:0];
        end
        if (i_en[8]) begin
            r_prod_g8 <= 47'(r_ce7) * 47'(G_K);
            r_d8      <= r_d7;
            r_ce8     <= r_ce7;
        end
    end

    assign o_mday  = 5'(r_ce8 - G_DAYS[n_g]);
    assign o_month = n_month;
    assign o_year  = (n_month >= 4'd3) ? $signed({1'b0, r_d8}) - YEAR_OFS_MAR
                                       : $signed({1'b0, r_d8}) - YEAR_OFS_JAN;
endmodule

[hdl/epoch_seconds_to_calendar_date_unit.sv]
// Channel  Dir  Handshake     Payload
// i_in     in   valid/ready   epoch_seconds (39b signed, seconds from J2000)
// o_out    out  valid/ready   cal_year, cal_month, cal_day, clock_hour,
//                             clock_minute, clock_second, out_of_range
//
// Ten-stage pipeline: a transaction enters every cycle unless a full pipeline is
// held by an output stall; the depth is set by the date path (three reciprocal
// multiplies, each followed by a register). Reset clears only the valid bits.
// Each stage holds while the one after it is full and stalled; empty stages
// keep taking transactions, so bubbles close up under an output stall.
// Top level; depends on epsc_pkg, epsc_in_if, epsc_out_if and the stage modules.
module epoch_seconds_to_calendar_date_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    epsc_in_if.sink       i_in,
    epsc_out_if.source    o_out
);
    import epsc_pkg::*;

    t_stage_en   r_vld;
    t_stage_en   w_en;
    logic [8:3]  r_oor;

    t_day        w_day;
    t_sod        w_sod;
    logic        w_oor2;
    t_year       w_year;
    t_month      w_month;
    t_mday       w_mday;
    t_hour       w_hour;
    t_minute     w_minute;
    t_second     w_second;

    t_year       r_year;
    t_month      r_month;
    t_mday       r_mday;
    t_hour       r_hour;
    t_minute     r_minute;
    t_second     r_second;
    logic        r_oor_out;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_en[NUM_STG-1] = !r_vld[NUM_STG-1] || o_out.ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    epsc_day_split u_split (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_epoch (i_in.epoch_seconds),
        .o_day   (w_day),
        .o_sod   (w_sod),
        .o_oor   (w_oor2)
    );

    epsc_date u_date (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_day   (w_day),
        .o_year  (w_year),
        .o_month (w_month),
        .o_mday  (w_mday)
    );

    epsc_time_of_day u_tod (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sod    (w_sod),
        .o_hour   (w_hour),
        .o_minute (w_minute),
        .o_second (w_second)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_oor[3] <= w_oor2;
        end
        for (int k = 4; k <= 8; k++) begin
            if (w_en[k]) begin
                r_oor[k] <= r_oor[k-1];
            end
        end
        // output register; fields forced to zero for an out-of-range input
        if (w_en[NUM_STG-1]) begin
            r_oor_out <= r_oor[8];
            r_year    <= r_oor[8] ? '0 : w_year;
            r_month   <= r_oor[8] ? '0 : w_month;
            r_mday    <= r_oor[8] ? '0 : w_mday;
            r_hour    <= r_oor[8] ? '0 : w_hour;
            r_minute  <= r_oor[8] ? '0 : w_minute;
            r_second  <= r_oor[8] ? '0 : w_second;
        end
    end

    assign i_in.ready         = w_en[0];
    assign o_out.valid        = r_vld[NUM_STG-1];
    assign o_out.cal_year     = r_year;
    assign o_out.cal_month    = r_month;
    assign o_out.cal_day      = r_mday;
    assign o_out.clock_hour   = r_hour;
    assign o_out.clock_minute = r_minute;
    assign o_out.clock_second = r_second;
    assign o_out.out_of_range = r_oor_out;
endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for epoch_seconds_to_calendar_date_unit.
// Drives epoch seconds over epsc_in_if and checks each date/time on epsc_out_if
// against an integer predictor kept in a scoreboard class. Needs epsc_pkg and both interfaces.
`timescale 1ns / 1ps

module tb_top;
    import epsc_pkg::*;

    localparam longint SECS_DAY    = 86400;
    localparam longint MID_2000    = -43200;          // 2000-01-01 00:00
    localparam int     NUM_RANDOM  = 787;
    localparam int     QUIET_ITEMS = 150;
    localparam int     HOLD_CYCLES = 80;
    localparam int     CYCLE_LIMIT = 200000;

    typedef struct packed {
        t_year   year;
        t_month  month;
        t_mday   mday;
        t_hour   hour;
        t_minute minute;
        t_second second;
        logic    oor;
    } t_date_rec;

    class date_scoreboard;
        t_date_rec pending_dates[$];
        int        err_cnt = 0;

        function t_date_rec to_calendar(t_epoch s);
            longint    sv, t, dn, sod, a, b, c, d, e, g, dd, mo, yr;
            t_date_rec r;
            r  = '0;
            sv = s;
            if (sv < longint'(EPOCH_LOW) || sv > longint'(EPOCH_HIGH)) begin
                r.oor = 1'b1;
                return r;
            end
            // midnight-based day count from JD 0
            t   = sv + longint'(JD0_OFFSET);
            dn  = t / SECS_DAY;
            sod = t % SECS_DAY;
            b   = dn;
            if (dn > longint'(GREG_START)) begin
                a = (4 * dn - 7468865) / 146097;
                b = dn + a - a / 4 + 1;
            end
            c  = b + 1524;
            d  = (100 * c - 12210) / 36525;
            e  = (36525 * d) / 100;
            g  = ((c - e) * 10000) / 306001;
            dd = c - e - (306001 * g) / 10000;
            mo = (g <= 13) ? g - 1 : g - 13;
            yr = (mo >= 3) ? d - 4716 : d - 4715;
            r.year   = t_year'(yr);
            r.month  = t_month'(mo);
            r.mday   = t_mday'(dd);
            r.hour   = t_hour'(sod / 3600);
            r.minute = t_minute'((sod / 60) % 60);
            r.second = t_second'(sod % 60);
            return r;
        endfunction

        function void note_epoch(t_epoch s);
            pending_dates.push_back(to_calendar(s));
        endfunction

        function void check_date(t_date_rec got);
            t_date_rec want;
            if (pending_dates.size() == 0) begin
                $error("result transaction with no pending input");
                err_cnt++;
                return;
            end
            want = pending_dates.pop_front();
            if (got.year != want.year) begin
                $error("cal_year: expected %0d, got %0d",
                       $signed(want.year), $signed(got.year));
                err_cnt++;
            end
            if (got.month != want.month) begin
                $error("cal_month: expected %0d, got %0d", want.month, got.month);
                err_cnt++;
            end
            if (got.mday != want.mday) begin
                $error("cal_day: expected %0d, got %0d", want.mday, got.mday);
                err_cnt++;
            end
            if (got.hour != want.hour) begin
                $error("clock_hour: expected %0d, got %0d", want.hour, got.hour);
                err_cnt++;
            end
            if (got.minute != want.minute) begin
                $error("clock_minute: expected %0d, got %0d", want.minute, got.minute);
                err_cnt++;
            end
            if (got.second != want.second) begin
                $error("clock_second: expected %0d, got %0d", want.second, got.second);
                err_cnt++;
            end
            if (got.oor != want.oor) begin
                $error("out_of_range: expected %0d, got %0d", want.oor, got.oor);
                err_cnt++;
            end
        endfunction

        function int pending();
            return pending_dates.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    epsc_in_if  in_ch ();
    epsc_out_if out_ch ();

    epoch_seconds_to_calendar_date_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    date_scoreboard sb;
    bit             quiet_phase   = 1'b0;
    int             hold_req_cnt  = 0;
    int             hold_seen_cnt = 0;
    int             cycle_cnt     = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic int rand_gap();
        if (quiet_phase || $urandom_range(0, 5) != 0)
            return 0;
        return $urandom_range(1, 17);
    endfunction

    // receiver: random stall bursts plus one long hold-off on request
    initial begin
        int idle_left;
        int hold_left;
        idle_left    = 0;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_req_cnt != hold_seen_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                out_ch.ready = 1'b0;
                idle_left--;
            end else begin
                out_ch.ready = 1'b1;
                idle_left    = rand_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_date_rec got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.year   = out_ch.cal_year;
            got.month  = out_ch.cal_month;
            got.mday   = out_ch.cal_day;
            got.hour   = out_ch.clock_hour;
            got.minute = out_ch.clock_minute;
            got.second = out_ch.clock_second;
            got.oor    = out_ch.out_of_range;
            sb.check_date(got);
        end
    end

    task automatic send_epoch(t_epoch v, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid         = 1'b1;
        in_ch.epoch_seconds = v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_epoch(v);
    endtask

    function automatic longint rand_span(longint span);
        longint unsigned w;
        w = {$urandom, $urandom};
        return longint'(w % longint'(span));
    endfunction

    function automatic t_epoch pick_epoch();
        logic [63:0] w;
        longint      greg_first, max_day, base;
        int          pick;
        greg_first = (longint'(GREG_START) + 1) * SECS_DAY - longint'(JD0_OFFSET);
        max_day    = (longint'(EPOCH_HIGH) + longint'(JD0_OFFSET)) / SECS_DAY;
        pick       = $urandom_range(0, 99);
        if (pick < 8) begin
            w = {$urandom, $urandom};
            return w[38:0];
        end else if (pick < 14) begin
            base = ($urandom_range(0, 1) != 0) ? longint'(EPOCH_LOW) : longint'(EPOCH_HIGH);
            return t_epoch'(base + longint'($urandom_range(0, 6000)) - 3000);
        end else if (pick < 24) begin
            return t_epoch'(greg_first + rand_span(400 * SECS_DAY) - 200 * SECS_DAY);
        end else if (pick < 40) begin
            // a few seconds either side of midnight
            base = rand_span(max_day + 1) * SECS_DAY - longint'(JD0_OFFSET);
            return t_epoch'(base + longint'($urandom_range(0, 7)) - 4);
        end
        return t_epoch'(longint'(EPOCH_LOW) +
                        rand_span(longint'(EPOCH_HIGH) - longint'(EPOCH_LOW) + 1));
    endfunction

    initial begin
        longint directed[$];
        longint greg_first, yr0_start, mar_1900;
        sb                  = new;
        in_ch.valid         = 1'b0;
        in_ch.epoch_seconds = '0;
        i_rst_n             = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        greg_first = (longint'(GREG_START) + 1) * SECS_DAY - longint'(JD0_OFFSET);
        yr0_start  = 1721058 * SECS_DAY - longint'(JD0_OFFSET);
        mar_1900   = MID_2000 - (36524 - 59) * SECS_DAY;
        directed   = '{
            longint'(EPOCH_LOW), longint'(EPOCH_LOW) - 1,
            longint'(EPOCH_HIGH), longint'(EPOCH_HIGH) + 1,
            -(longint'(1) << 38), (longint'(1) << 38) - 1,
            0, -1, MID_2000, MID_2000 - 1,
            MID_2000 + 59 * SECS_DAY, MID_2000 + 60 * SECS_DAY - 1,
            MID_2000 + 60 * SECS_DAY,
            greg_first, greg_first - 1, greg_first - SECS_DAY, greg_first + 43199,
            yr0_start, yr0_start - 1,
            mar_1900 - SECS_DAY, mar_1900, mar_1900 - 1,
            longint'(EPOCH_LOW) + SECS_DAY - 1
        };
        foreach (directed[i])
            send_epoch(t_epoch'(directed[i]), rand_gap());

        // long output stall while inputs keep coming back to back
        hold_req_cnt++;
        repeat (40) send_epoch(pick_epoch(), 0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM - QUIET_ITEMS)
                quiet_phase = 1'b1;
            send_epoch(pick_epoch(), rand_gap());
        end
        @(negedge i_clk);
        in_ch.valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (NUM_STG + 10) @(posedge i_clk);
        if (sb.err_cnt == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
